// ===== sv/tpp_pkg.sv =====
// Shared types, codes and tables for the timer period planner.
`timescale 1ns / 1ps
package tpp_pkg;
  localparam int ClockW = 25;
  localparam int MinW = 8;
  localparam int CountW = 16;
  localparam int UnitW = 20;
  localparam int KindW = 2;
  localparam int NumerW = ClockW + CountW;   // 41
  localparam int DenW = UnitW + 10;          // divider up to 1024
  localparam int TopW = 16;
  localparam int ETicksW = 32;
  localparam int QueueDepth = 4;

  localparam logic [ClockW-1:0] ClockReset = 25'd16000000;
  localparam logic [MinW-1:0] MinReset = 8'd150;

  typedef enum logic [0:0] {
    REG_CLOCK_HZ = 1'b0,
    REG_MIN_CYCLES = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0,
    ERR_CLOCK_ZERO = 3'd1,
    ERR_UNIT_ZERO = 3'd2,
    ERR_TOO_SHORT = 3'd3,
    ERR_BAD_TIMER = 3'd4,
    ERR_TOP_ZERO = 3'd5,
    ERR_TOP_LARGE = 3'd6
  } err_t;

  localparam logic [KindW-1:0] KIND_T16 = 2'd0;
  localparam logic [KindW-1:0] KIND_SECOND8 = 2'd2;
  localparam logic [KindW-1:0] KIND_BAD = 2'd3;

  // One request on its way from front to back.
  typedef struct packed {
    logic [NumerW-1:0] numer;
    logic [UnitW-1:0] unit;
    logic [KindW-1:0] kind;
    logic clk_zero;
    logic [MinW-1:0] min_cycles;
  } req_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic [2:0] divider_select;
    logic [2:0] clock_select_code;
    logic [TopW-1:0] compare_top;
    logic extended_mode;
    logic [ETicksW-1:0] extended_ticks;
  } res_t;

  function automatic logic [2:0] cs_code(input logic [KindW-1:0] kind,
                                         input logic [2:0] idx);
    logic [2:0] c;
    c = 3'd1;
    if (kind == KIND_SECOND8) begin
      case (idx)
        3'd0: c = 3'd1;
        3'd1: c = 3'd2;
        3'd2: c = 3'd4;
        3'd3: c = 3'd6;
        default: c = 3'd7;
      endcase
    end else begin
      c = idx + 3'd1;
    end
    return c;
  endfunction
endpackage

// ===== sv/tpp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tpp_divider #(
  parameter int NW = 42,
  parameter int DW = 30,
  parameter int TW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic out_valid,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  logic vld [NW+1];
  logic [NW-1:0] rem_s [NW+1];
  logic [NW-1:0] q_s [NW+1];
  logic [DW-1:0] d_s [NW+1];
  logic [TW-1:0] t_s [NW+1];

  assign vld[0] = in_valid;
  assign rem_s[0] = '0;
  assign q_s[0] = num;
  assign d_s[0] = den;
  assign t_s[0] = tag_in;

  // Each stage shifts in one dividend bit and tries a subtract.
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW:0] trial;
    logic [NW:0] diff;
    assign trial = {rem_s[s], q_s[s][NW-1]};
    assign diff = trial - {{(NW+1-DW){1'b0}}, d_s[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[NW]) begin
          rem_s[s+1] <= diff[NW-1:0];
          q_s[s+1] <= {q_s[s][NW-2:0], 1'b1};
        end else begin
          rem_s[s+1] <= trial[NW-1:0];
          q_s[s+1] <= {q_s[s][NW-2:0], 1'b0};
        end
        d_s[s+1] <= d_s[s];
        t_s[s+1] <= t_s[s];
      end
    end
  end

  assign out_valid = vld[NW];
  assign quo = q_s[NW];
  assign tag_out = t_s[NW];
endmodule

// ===== sv/tpp_front.sv =====
// Front end: takes requests, forms the product and classifies early errors.
`timescale 1ns / 1ps
module tpp_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [tpp_pkg::CountW-1:0] time_count,
  input  logic [tpp_pkg::UnitW-1:0] unit_divisor,
  input  logic [tpp_pkg::KindW-1:0] timer_kind,
  input  logic [tpp_pkg::ClockW-1:0] clock_hz,
  input  logic [tpp_pkg::MinW-1:0] min_cycles,
  output logic q_valid,
  input  logic q_stall,
  output tpp_pkg::req_t q_req
);
  // Single output register; refills whenever the queue takes it.
  assign in_stall = q_valid && q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_req.numer <= clock_hz * time_count;
      q_req.unit <= unit_divisor;
      q_req.kind <= timer_kind;
      q_req.clk_zero <= (clock_hz == '0);
      q_req.min_cycles <= min_cycles;
    end
  end
endmodule

// ===== sv/tpp_queue.sv =====
// Small FIFO between front and back.
`timescale 1ns / 1ps
module tpp_queue #(
  parameter int Depth = tpp_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  tpp_pkg::req_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output tpp_pkg::req_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  tpp_pkg::req_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign wr_stall = (cnt == (AW+1)'(Depth)) ? 1'b1 : 1'b0;
  assign rd_valid = (cnt != '0);
  assign rd_data = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end
endmodule

// ===== sv/tpp_back.sv =====
// Back end: scaled ticks, divider choice, rounded top and result register.
`timescale 1ns / 1ps
module tpp_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_stall,
  input  tpp_pkg::req_t q_req,
  output logic out_valid,
  input  logic out_stall,
  output tpp_pkg::res_t res
);
  // Two spare bits: the rounding numerator 2*numer + den needs 43 bits.
  localparam int NW = tpp_pkg::NumerW + 2;
  localparam int DW = tpp_pkg::DenW;
  localparam int TW = $bits(tpp_pkg::req_t);

  // Whole pipe advances together unless the result register is held.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign q_stall = !adv;

  // Pass 1: scaled = numer / unit.
  logic v1;
  logic [NW-1:0] scaled_w;
  tpp_pkg::req_t r1;
  logic unit_zero_in;
  logic [DW-1:0] den1;
  assign unit_zero_in = (q_req.unit == '0);
  assign den1 = unit_zero_in ? DW'(1) : DW'(q_req.unit);

  tpp_divider #(.NW(NW), .DW(DW), .TW(TW)) u_div1 (
    .clk, .rst, .adv,
    .in_valid(q_valid),
    .num({2'b00, q_req.numer}),
    .den(den1),
    .tag_in(q_req),
    .out_valid(v1),
    .quo(scaled_w),
    .tag_out(r1)
  );

  // Classify and choose divider from scaled ticks (register stage).
  logic v2;
  tpp_pkg::req_t r2;
  logic [tpp_pkg::NumerW-1:0] scaled2;
  logic [2:0] err2;
  logic [2:0] idx2;
  logic ext2;
  logic [tpp_pkg::NumerW-1:0] s;
  logic t16;
  logic [2:0] err_c, idx_c;
  logic ext_c;
  assign s = scaled_w[tpp_pkg::NumerW-1:0];
  assign t16 = (r1.kind == tpp_pkg::KIND_T16);

  // presc <= d  <=>  scaled <= d*cmax.
  always_comb begin
    logic [tpp_pkg::NumerW-1:0] lim [5];
    for (int i = 0; i < 5; i++) begin
      lim[i] = t16 ? (tpp_pkg::NumerW'(65535) << (3 * i - (i == 4 ? 2 : 0) - (i == 3 ? 1 : 0)))
                   : (tpp_pkg::NumerW'(255) << (3 * i - (i == 4 ? 2 : 0) - (i == 3 ? 1 : 0)));
    end
    err_c = tpp_pkg::ERR_OK;
    ext_c = 1'b0;
    idx_c = 3'd4;
    if (r1.clk_zero) err_c = tpp_pkg::ERR_CLOCK_ZERO;
    else if (r1.unit == '0) err_c = tpp_pkg::ERR_UNIT_ZERO;
    else if (s <= tpp_pkg::NumerW'(r1.min_cycles)) err_c = tpp_pkg::ERR_TOO_SHORT;
    else if (r1.kind == tpp_pkg::KIND_BAD) err_c = tpp_pkg::ERR_BAD_TIMER;
    if (s > lim[4]) ext_c = 1'b1;
    else if (s <= lim[0]) idx_c = 3'd0;
    else if (s <= lim[1]) idx_c = 3'd1;
    else if (s <= lim[2]) idx_c = 3'd2;
    else if (s <= lim[3]) idx_c = 3'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r2 <= r1;
      scaled2 <= s;
      err2 <= err_c;
      idx2 <= idx_c;
      ext2 <= ext_c;
    end
  end

  // Pass 2: top = (2*numer + den) / (2*den), den = divider * unit.
  logic [DW-1:0] den2;
  logic [NW-1:0] num2;
  logic [DW:0] den2x;
  logic [4:0] sh;
  always_comb begin
    case (idx2)
      3'd0: sh = 5'd0;
      3'd1: sh = 5'd3;
      3'd2: sh = 5'd6;
      3'd3: sh = 5'd8;
      default: sh = 5'd10;
    endcase
  end
  assign den2 = (r2.unit == '0) ? DW'(1) : (DW'(r2.unit) << sh);
  assign den2x = {den2, 1'b0};
  assign num2 = {1'b0, r2.numer, 1'b0} + NW'(den2);

  typedef struct packed {
    logic [tpp_pkg::KindW-1:0] kind;
    logic [2:0] err;
    logic [2:0] idx;
    logic ext;
    logic [tpp_pkg::NumerW-1:0] scaled;
  } mid_t;
  mid_t m_in, m_out;
  logic v3;
  logic [NW-1:0] top_w;
  assign m_in = '{kind: r2.kind, err: err2, idx: idx2, ext: ext2, scaled: scaled2};

  tpp_divider #(.NW(NW), .DW(DW+1), .TW($bits(mid_t))) u_div2 (
    .clk, .rst, .adv,
    .in_valid(v2),
    .num(num2),
    .den(den2x),
    .tag_in(m_in),
    .out_valid(v3),
    .quo(top_w),
    .tag_out(m_out)
  );

  // Final checks into the result register.
  tpp_pkg::res_t rc;
  logic [NW-1:0] cmax;
  always_comb begin
    cmax = (m_out.kind == tpp_pkg::KIND_T16) ? NW'(65535) : NW'(255);
    rc = '0;
    if (m_out.err != tpp_pkg::ERR_OK) begin
      rc.error_code = m_out.err;
    end else if (m_out.ext) begin
      rc.error_code = tpp_pkg::ERR_OK;
      rc.divider_select = 3'd4;
      rc.clock_select_code = tpp_pkg::cs_code(m_out.kind, 3'd4);
      rc.compare_top = cmax[tpp_pkg::TopW-1:0];
      rc.extended_mode = 1'b1;
      rc.extended_ticks = tpp_pkg::ETicksW'(m_out.scaled >> 10);
    end else if (top_w == '0) begin
      rc.error_code = tpp_pkg::ERR_TOP_ZERO;
    end else if (top_w > cmax) begin
      rc.error_code = tpp_pkg::ERR_TOP_LARGE;
    end else begin
      rc.divider_select = m_out.idx;
      rc.clock_select_code = tpp_pkg::cs_code(m_out.kind, m_out.idx);
      rc.compare_top = top_w[tpp_pkg::TopW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) res <= rc;
  end
endmodule

// ===== sv/timer_period_planner_top.sv =====
// Top level of the timer period planner: config registers, front, queue, back.
// Path: front register loads on the accepting edge, then the queue, two 43-stage
// divider pipes and 2 register stages lead to the result.
// Throughput: one transaction per cycle unless out_stall holds; one bit per divider stage.
// Reset: synchronous rst empties the pipes and queue, clock_hz = 16000000, min_cycles = 150.
`timescale 1ns / 1ps
module timer_period_planner_top #(
  parameter int QueueDepth = tpp_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] time_count,
  input  logic [19:0] unit_divisor,
  input  logic [1:0] timer_kind,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] error_code,
  output logic [2:0] divider_select,
  output logic [2:0] clock_select_code,
  output logic [15:0] compare_top,
  output logic extended_mode,
  output logic [31:0] extended_ticks,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [24:0] cfg_data
);
  logic [tpp_pkg::ClockW-1:0] clock_hz;
  logic [tpp_pkg::MinW-1:0] min_cycles;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= tpp_pkg::ClockReset;
      min_cycles <= tpp_pkg::MinReset;
    end else if (cfg_we) begin
      case (cfg_index)
        tpp_pkg::REG_CLOCK_HZ: clock_hz <= cfg_data;
        tpp_pkg::REG_MIN_CYCLES: min_cycles <= cfg_data[tpp_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_stall, b_valid, b_stall;
  tpp_pkg::req_t f_req, b_req;
  tpp_pkg::res_t res;

  tpp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .time_count, .unit_divisor, .timer_kind,
    .clock_hz, .min_cycles, .q_valid(f_valid), .q_stall(f_stall), .q_req(f_req)
  );

  tpp_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_req),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_req)
  );

  tpp_back u_back (
    .clk, .rst, .q_valid(b_valid), .q_stall(b_stall), .q_req(b_req),
    .out_valid, .out_stall, .res
  );

  assign error_code = res.error_code;
  assign divider_select = res.divider_select;
  assign clock_select_code = res.clock_select_code;
  assign compare_top = res.compare_top;
  assign extended_mode = res.extended_mode;
  assign extended_ticks = res.extended_ticks;

  // Error results carry no settings.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != tpp_pkg::ERR_OK |-> compare_top == '0 && !extended_mode)
    else $error("error result carries settings");
  // Extended mode always uses the largest divider.
  a_ext_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && extended_mode |-> divider_select == 3'd4)
    else $error("extended mode without divider 1024");
  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(compare_top))
    else $error("stalled result changed");
endmodule

// ===== tb/sv/timer_period_planner_checker.sv =====
// Checker for the timer period planner: predicts each result and compares it.
`timescale 1ns / 1ps
module timer_period_planner_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [15:0] time_count,
  input  logic [19:0] unit_divisor,
  input  logic [1:0] timer_kind,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [2:0] error_code,
  input  logic [2:0] divider_select,
  input  logic [2:0] clock_select_code,
  input  logic [15:0] compare_top,
  input  logic extended_mode,
  input  logic [31:0] extended_ticks,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [24:0] cfg_data,
  output int fail_count,
  output int pending_count,
  output int result_count
);
  logic [24:0] clock_hz_q;
  logic [7:0] min_cycles_q;
  tpp_pkg::res_t planned_q[$];

  // Work out the timer settings for one request
  function automatic tpp_pkg::res_t plan_period(input logic [15:0] count,
                                                input logic [19:0] unit,
                                                input logic [1:0] kind);
    tpp_pkg::res_t r;
    logic [63:0] numer, scaled, cmax, presc, den, top, divv;
    logic [2:0] idx;
    r = '0;
    numer = 64'(clock_hz_q) * 64'(count);
    if (clock_hz_q == 0) begin
      r.error_code = tpp_pkg::ERR_CLOCK_ZERO;
      return r;
    end
    if (unit == 0) begin
      r.error_code = tpp_pkg::ERR_UNIT_ZERO;
      return r;
    end
    scaled = numer / 64'(unit);
    if (scaled <= 64'(min_cycles_q)) begin
      r.error_code = tpp_pkg::ERR_TOO_SHORT;
      return r;
    end
    if (kind == tpp_pkg::KIND_BAD) begin
      r.error_code = tpp_pkg::ERR_BAD_TIMER;
      return r;
    end
    cmax = (kind == tpp_pkg::KIND_T16) ? 64'd65535 : 64'd255;
    presc = (scaled + cmax - 1) / cmax;
    if (presc > 1024) begin
      r.error_code = tpp_pkg::ERR_OK;
      r.divider_select = 3'd4;
      r.clock_select_code = (kind == tpp_pkg::KIND_SECOND8) ? 3'd7 : 3'd5;
      r.compare_top = cmax[15:0];
      r.extended_mode = 1'b1;
      r.extended_ticks = 32'(scaled >> 10);
      return r;
    end
    idx = 3'd4;
    // Dividers 1, 8, 64, 256, 1024 as shifts 0, 3, 6, 8, 10
    for (int i = 4; i >= 0; i--) begin
      divv = 64'd1 << (3 * i - (i == 4 ? 2 : 0) - (i == 3 ? 1 : 0));
      if (divv >= presc) idx = 3'(i);
    end
    divv = 64'd1 << (3 * idx - (idx == 3'd4 ? 2 : 0) - (idx == 3'd3 ? 1 : 0));
    den = divv * 64'(unit);
    top = (numer + den / 2) / den;
    if (top == 0) begin
      r.error_code = tpp_pkg::ERR_TOP_ZERO;
      return r;
    end
    if (top > cmax) begin
      r.error_code = tpp_pkg::ERR_TOP_LARGE;
      return r;
    end
    r.divider_select = idx;
    if (kind == tpp_pkg::KIND_SECOND8) begin
      case (idx)
        3'd0: r.clock_select_code = 3'd1;
        3'd1: r.clock_select_code = 3'd2;
        3'd2: r.clock_select_code = 3'd4;
        3'd3: r.clock_select_code = 3'd6;
        default: r.clock_select_code = 3'd7;
      endcase
    end else begin
      r.clock_select_code = idx + 3'd1;
    end
    r.compare_top = top[15:0];
    return r;
  endfunction

  // Track config, predict on input, compare on output
  always @(posedge clk) begin
    tpp_pkg::res_t want, got;
    if (rst) begin
      clock_hz_q <= tpp_pkg::ClockReset;
      min_cycles_q <= tpp_pkg::MinReset;
      planned_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tpp_pkg::REG_CLOCK_HZ) clock_hz_q <= cfg_data;
        else min_cycles_q <= cfg_data[7:0];
      end
      if (in_valid && !in_stall)
        planned_q.push_back(plan_period(time_count, unit_divisor, timer_kind));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        got = '{error_code, divider_select, clock_select_code, compare_top,
                extended_mode, extended_ticks};
        if (planned_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = planned_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = planned_q.size();
  end
endmodule

// ===== tb/sv/timer_period_planner_top_tb.sv =====
// Testbench top for the timer period planner: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module timer_period_planner_top_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] time_count = '0;
  logic [19:0] unit_divisor = '0;
  logic [1:0] timer_kind = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] error_code, divider_select, clock_select_code;
  logic [15:0] compare_top;
  logic extended_mode;
  logic [31:0] extended_ticks;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [24:0] cfg_data = '0;
  int fail_count, pending_count, result_count;
  bit calm = 1'b0;
  int sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timer_period_planner_top uut (.*);
  timer_period_planner_checker chk (.*);

  // Receiver stall, off during calm stretches
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 35);

  // Send one request, holding it until accepted
  task automatic send_request(input logic [15:0] c, input logic [19:0] u, input logic [1:0] k);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    time_count <= c;
    unit_divisor <= u;
    timer_kind <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input tpp_pkg::reg_index_t idx, input logic [24:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Let the block drain before a register write or the end
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Random request: units weighted toward s/ms/us, counts often small
  task automatic random_request();
    logic [19:0] u;
    logic [15:0] c;
    case ($urandom_range(5))
      0: u = 20'd1;
      1: u = 20'd1000;
      2: u = 20'd1000000;
      3: u = 20'($urandom_range(1000000));
      default: u = 20'($urandom);
    endcase
    c = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(300));
    send_request(c, u, 2'($urandom_range(3)));
  endtask

  initial begin
    logic [24:0] clocks [5];
    logic [7:0] mins [5];
    clocks = '{25'd16000000, 25'd20000000, 25'd1, 25'h1FFFFFF, 25'd0};
    mins = '{8'd150, 8'd0, 8'd255, 8'd0, 8'd10};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: unit-zero, too-short and bad-timer errors, each divider, extended mode, field extremes
    send_request(16'd1, 20'd1000, 2'd0);
    send_request(16'd10, 20'd0, 2'd0);
    send_request(16'd100, 20'd1000000, 2'd3);
    send_request(16'd1, 20'd1000, 2'd3);
    send_request(16'd4, 20'd1000, 2'd0);
    send_request(16'd40, 20'd1000, 2'd0);
    send_request(16'd262, 20'd1000, 2'd0);
    send_request(16'd1000, 20'd1000, 2'd0);
    send_request(16'd4000, 20'd1000, 2'd0);
    send_request(16'd65535, 20'd1, 2'd0);
    send_request(16'd100, 20'd1000000, 2'd1);
    send_request(16'd1, 20'd1000, 2'd1);
    send_request(16'd10, 20'd1000, 2'd2);
    send_request(16'd100, 20'd1000, 2'd2);
    send_request(16'd65535, 20'd1000, 2'd2);
    send_request(16'd65535, 20'hFFFFF, 2'd1);
    send_request(16'd0, 20'd1, 2'd0);
    send_request(16'hFFFF, 20'hFFFFF, 2'd0);
    drain();
    // Phases over register settings, with a calm stretch in one
    for (int p = 0; p < 5; p++) begin
      write_reg(tpp_pkg::REG_CLOCK_HZ, clocks[p]);
      write_reg(tpp_pkg::REG_MIN_CYCLES, 25'(mins[p]));
      calm = (p == 1);
      for (int i = 0; i < (p == 4 ? 60 : 210); i++) random_request();
      drain();
    end
    calm = 1'b0;
    $display("Covered %0d requests, %0d results, five clock/minimum settings incl. extremes.",
             sent, result_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
